@@ rtl/rsr_pkg.sv @@
// shared types and constants for the replacement-selection run generator
// used by rsr_cell, replacement_selection_runs and the testbench; no other dependencies
package rsr_pkg;

  // number of selection slots and derived widths
  localparam int SLOTS  = 8;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CFG_W  = 4;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KEY_W  = 32;
  localparam int RUN_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // input kinds carried in tuser
  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // running minimum handed from cell to cell during a scan
  typedef struct packed {
    logic              live;
    logic              found;
    logic              valid_any;
    logic              open_many;
    logic              valid_many;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
  } cand_t;

  // update command broadcast from the controller to every cell
  typedef struct packed {
    logic              write;
    logic              invalidate;
    logic              freeze;
    logic              unfreeze_all;
    logic              clear_all;
    logic [IDX_W-1:0]  sel;
    logic [KEY_W-1:0]  key;
  } cmd_t;

endpackage

@@ rtl/replacement_selection_runs.sv @@
// top level of the replacement-selection run generator: controller, config
// register, output register and the chain of rsr_cell slots; uses rsr_pkg
//
// Usage:
//   Input stream s_axis: tuser is the kind (0 = key, 1 = end of input),
//   tdata is the signed 32-bit key. Output stream m_axis: tdata carries
//   out_key and run_index, tuser is run_end, tlast marks the final result
//   of the input item. cfg_valid/cfg_data write slots_in_use (reset 8);
//   write it only while the block is idle.
//   While the slots fill, a key is stored in the next slot and gives no result.
//   After that each key starts a scan along the slot chain: the start register
//   launches it, it passes through every cell of the chain, and the emit step
//   replaces the slot and registers the result, holding while the output
//   register is full; the next item is taken only once the emit step is
//   done. An end-of-input item repeats the scan once per held key, one
//   result per scan, and then clears the slots and run count.
//   A held result sits in the output register; new input is accepted while
//   it waits, but the next result waits until the receiver takes it.
//   Reset empties all slots, zeroes the run counter and drops tvalid.
module replacement_selection_runs (
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,      // slots_in_use
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // key
  input  logic        s_axis_tuser,  // op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_key [31:0], run_index [47:32]
  output logic        m_axis_tuser,  // run_end
  output logic        m_axis_tlast   // last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [rsr_pkg::CFG_W-1:0]     slots_in_use;
  logic [rsr_pkg::CNT_W-1:0]     fill_count;
  logic [rsr_pkg::RUN_W-1:0]     run_counter;
  logic                          hold_op;
  logic [rsr_pkg::KEY_W-1:0]     hold_key;
  logic                          start;
  logic                          out_valid;
  logic [rsr_pkg::KEY_W-1:0]     out_key;
  logic [rsr_pkg::RUN_W-1:0]     out_run;
  logic                          out_end;
  logic                          out_last;

  logic                          accept;
  logic                          out_free;
  logic [rsr_pkg::CMP_W-1:0]     cfg_ext;
  logic [rsr_pkg::CMP_W-1:0]     used;
  logic                          filling;
  logic                          key_less;
  logic                          run_end;
  logic                          emit;
  rsr_pkg::cmd_t                 cmd;
  rsr_pkg::cand_t                chain [rsr_pkg::SLOTS+1];
  rsr_pkg::cand_t                res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // clamp slots_in_use to 1..SLOTS
  assign cfg_ext = rsr_pkg::CMP_W'(slots_in_use);
  always_comb begin
    used = cfg_ext;
    if (cfg_ext == '0) begin
      used = rsr_pkg::CMP_W'(1);
    end else if (cfg_ext > rsr_pkg::CMP_W'(rsr_pkg::SLOTS)) begin
      used = rsr_pkg::CMP_W'(rsr_pkg::SLOTS);
    end
  end
  assign filling = (rsr_pkg::CMP_W'(fill_count) < used);

  // chain of slot cells
  assign res = chain[rsr_pkg::SLOTS];
  always_comb begin
    chain[0]       = '0;
    chain[0].live  = start;
  end

  for (genvar g = 0; g < rsr_pkg::SLOTS; g++) begin : g_cell
    rsr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (rsr_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  // result decision once the scan has passed the last cell
  assign key_less = $signed(hold_key) < $signed(res.key);
  assign run_end  = (hold_op == rsr_pkg::OP_DRAIN) ? !res.open_many
                                                   : (key_less && !res.open_many);
  assign emit     = (state == ST_EMIT) && res.found && out_free;

  // slot update commands
  always_comb begin
    cmd = '0;
    if (accept && (s_axis_tuser == rsr_pkg::OP_KEY) && filling) begin
      cmd.write = 1'b1;
      cmd.sel   = fill_count[rsr_pkg::IDX_W-1:0];
      cmd.key   = s_axis_tdata;
    end else if ((state == ST_EMIT) && !res.found) begin
      if (hold_op == rsr_pkg::OP_DRAIN) begin
        cmd.clear_all = 1'b1;
      end else begin
        cmd.write = 1'b1;
        cmd.sel   = '0;
        cmd.key   = hold_key;
      end
    end else if (emit) begin
      cmd.sel          = res.idx;
      cmd.key          = hold_key;
      cmd.unfreeze_all = run_end;
      if (hold_op == rsr_pkg::OP_DRAIN) begin
        cmd.invalidate = 1'b1;
        cmd.clear_all  = !res.valid_many;
      end else begin
        cmd.write  = 1'b1;
        cmd.freeze = key_less;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !((s_axis_tuser == rsr_pkg::OP_KEY) && filling)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.live) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res.found) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          if ((hold_op == rsr_pkg::OP_DRAIN) && res.valid_many) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= rsr_pkg::CFG_RESET;
      fill_count   <= '0;
      run_counter  <= '0;
      start        <= 1'b0;
    end else begin
      state <= state_next;
      start <= (state_next == ST_SCAN) && (state != ST_SCAN);
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end
      if (cmd.clear_all) begin
        fill_count  <= '0;
        run_counter <= '0;
      end else begin
        if (accept && (s_axis_tuser == rsr_pkg::OP_KEY) && filling) begin
          fill_count <= fill_count + rsr_pkg::CNT_W'(1);
        end
        if (emit && run_end) begin
          run_counter <= run_counter + rsr_pkg::RUN_W'(1);
        end
      end
    end
  end

  // held input item
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op  <= s_axis_tuser;
      hold_key <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_key  <= res.key;
      out_run  <= run_counter;
      out_end  <= run_end;
      out_last <= (hold_op == rsr_pkg::OP_DRAIN) ? !res.valid_many : 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_run, out_key};
  assign m_axis_tuser  = out_end;
  assign m_axis_tlast  = out_last;

  // a new result appears only out of the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit step");

  // fill count never passes the slot count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= rsr_pkg::CNT_W'(rsr_pkg::SLOTS))
    else $error("fill count out of range");

  // a finished drain leaves the run counter and fill count at zero
  a_drain_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> (run_counter == '0) && (fill_count == '0))
    else $error("drain did not clear counters");

  // a scan starts only when entering the scan state
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_SCAN) && ($past(state) != ST_SCAN))
    else $error("scan started out of sequence");

  // the chain delivers its result only while scanning
  a_chain_done: assert property (@(posedge clk) disable iff (rst)
    res.live |-> (state == ST_SCAN))
    else $error("scan result outside scan state");

endmodule

@@ rtl/rsr_cell.sv @@
// one selection slot: key, valid and frozen bits, plus one stage of the
// running-minimum chain; depends on rsr_pkg
module rsr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rsr_pkg::IDX_W-1:0] cell_idx,
  input  rsr_pkg::cmd_t             cmd,
  input  rsr_pkg::cand_t            cand_in,
  output rsr_pkg::cand_t            cand_out
);

  logic [rsr_pkg::KEY_W-1:0] key;
  logic                      valid;
  logic                      frozen;
  logic                      hit;
  logic                      open;
  logic                      take;
  rsr_pkg::cand_t            cand_next;

  assign hit  = (cmd.sel == cell_idx);
  assign open = valid && !frozen;
  assign take = open && (!cand_in.found || ($signed(key) < $signed(cand_in.key)));

  // slot state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      frozen <= 1'b0;
    end else if (cmd.clear_all) begin
      valid  <= 1'b0;
      frozen <= 1'b0;
    end else if (hit && cmd.write) begin
      valid  <= 1'b1;
      frozen <= cmd.freeze && !cmd.unfreeze_all;
    end else if (hit && cmd.invalidate) begin
      valid  <= 1'b0;
      frozen <= 1'b0;
    end else if (cmd.unfreeze_all && valid) begin
      frozen <= 1'b0;
    end
  end

  // key storage, no reset needed
  always_ff @(posedge clk) begin
    if (hit && cmd.write) begin
      key <= cmd.key;
    end
  end

  // fold this slot into the passing minimum
  always_comb begin
    cand_next            = cand_in;
    cand_next.found      = cand_in.found || open;
    cand_next.valid_any  = cand_in.valid_any || valid;
    cand_next.open_many  = cand_in.open_many || (cand_in.found && open);
    cand_next.valid_many = cand_in.valid_many || (cand_in.valid_any && valid);
    if (take) begin
      cand_next.idx = cell_idx;
      cand_next.key = key;
    end
  end

  // chain stage register, fields held while no scan passes
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.live <= 1'b0;
    end else begin
      cand_out.live <= cand_in.live;
    end
    if (cand_in.live) begin
      cand_out.found      <= cand_next.found;
      cand_out.valid_any  <= cand_next.valid_any;
      cand_out.open_many  <= cand_next.open_many;
      cand_out.valid_many <= cand_next.valid_many;
      cand_out.idx        <= cand_next.idx;
      cand_out.key        <= cand_next.key;
    end
  end

endmodule

@@ tb/rsr_run_checker.sv @@
// checker for replacement_selection_runs: watches the config, input and result
// channels, predicts every run key from its own slot model and compares; uses rsr_pkg
module rsr_run_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,      // slots_in_use
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // key
  input  logic        s_axis_tuser,  // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,  // out_key [31:0], run_index [47:32]
  input  logic        m_axis_tuser,  // run_end
  input  logic        m_axis_tlast,  // last
  output int          errors,
  output int          pending,
  output int          keys_out,
  output int          runs_closed
);

  localparam int SLOTS = rsr_pkg::SLOTS;
  localparam int KEY_W = rsr_pkg::KEY_W;
  localparam int RUN_W = rsr_pkg::RUN_W;
  localparam int CFG_W = rsr_pkg::CFG_W;

  // one key written to a run, as it should appear on the result channel
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
    logic             run_end;
    logic             last;
  } run_key_t;

  run_key_t         keys_due[$];
  logic [KEY_W-1:0] slot_key [SLOTS];
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] slot_frozen;
  int               fill;
  logic [RUN_W-1:0] run_no;
  logic [CFG_W-1:0] slots_cfg;
  int               err_n;
  int               shown;
  int               out_n;
  int               run_n;

  // register value clamped to the slots that exist
  function automatic int slots_used();
    int m;
    m = int'(slots_cfg);
    if (m < 1) m = 1;
    if (m > SLOTS) m = SLOTS;
    return m;
  endfunction

  // smallest open key, lowest slot on ties; -1 when nothing is open
  function automatic int smallest_open();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && !slot_frozen[i]) begin
        if (best < 0) best = i;
        else if ($signed(slot_key[i]) < $signed(slot_key[best])) best = i;
      end
    end
    return best;
  endfunction

  // close the run once every held slot is frozen
  function automatic logic close_run();
    if ((slot_valid & ~slot_frozen) != '0) return 1'b0;
    slot_frozen = slot_frozen & ~slot_valid;
    run_no = run_no + 1'b1;
    return 1'b1;
  endfunction

  // apply one input item to the slot model and queue the keys it emits
  task automatic select_step(input logic op, input logic [KEY_W-1:0] key);
    int       idx;
    int       n;
    run_key_t r;
    n = 0;
    if (op == rsr_pkg::OP_KEY) begin
      if (fill < slots_used()) begin
        // still filling: store and stay silent
        slot_key[fill]    = key;
        slot_valid[fill]  = 1'b1;
        slot_frozen[fill] = 1'b0;
        fill++;
      end else begin
        idx = smallest_open();
        if (idx < 0) begin
          slot_key[0]    = key;
          slot_valid[0]  = 1'b1;
          slot_frozen[0] = 1'b0;
        end else begin
          r.key = slot_key[idx];
          r.run = run_no;
          slot_key[idx] = key;
          // a smaller newcomer cannot join the current run
          if ($signed(key) < $signed(r.key)) slot_frozen[idx] = 1'b1;
          r.run_end = close_run();
          r.last    = 1'b1;
          keys_due.push_back(r);
        end
      end
    end else begin
      // end of input: empty the slots run by run
      while (slot_valid != '0 && n < SLOTS) begin
        idx = smallest_open();
        if (idx < 0) break;
        r.key = slot_key[idx];
        r.run = run_no;
        slot_valid[idx]  = 1'b0;
        slot_frozen[idx] = 1'b0;
        r.run_end = close_run();
        r.last    = 1'b0;
        keys_due.push_back(r);
        n++;
      end
      if (n > 0) keys_due[keys_due.size() - 1].last = 1'b1;
      slot_valid  = '0;
      slot_frozen = '0;
      fill        = 0;
      run_no      = '0;
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    err_n++;
    if (shown < 40) begin
      shown++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // compare one result item with the oldest key due
  task automatic check_result();
    run_key_t want;
    if (keys_due.size() == 0) begin
      err_n++;
      if (shown < 40) begin
        shown++;
        $display("%0t: result with nothing due, expected none, actual key %h run %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[47:32]);
      end
      return;
    end
    want = keys_due.pop_front();
    out_n++;
    if (m_axis_tuser) run_n++;
    if (m_axis_tdata[31:0] !== want.key) flag("out_key", want.key, m_axis_tdata[31:0]);
    if (m_axis_tdata[47:32] !== want.run)
      flag("run_index", 32'(want.run), 32'(m_axis_tdata[47:32]));
    if (m_axis_tuser !== want.run_end) flag("run_end", 32'(want.run_end), 32'(m_axis_tuser));
    if (m_axis_tlast !== want.last) flag("last", 32'(want.last), 32'(m_axis_tlast));
  endtask

  // handshakes are sampled at the clock edge; results before new input
  always @(posedge clk) begin
    if (rst) begin
      keys_due.delete();
      slot_valid  = '0;
      slot_frozen = '0;
      fill        = 0;
      run_no      = '0;
      slots_cfg   = rsr_pkg::CFG_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_valid && cfg_ready) slots_cfg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) select_step(s_axis_tuser, s_axis_tdata);
    end
    errors      <= err_n;
    pending     <= keys_due.size();
    keys_out    <= out_n;
    runs_closed <= run_n;
  end

endmodule

@@ tb/replacement_selection_runs_tb.sv @@
// top of the replacement_selection_runs testbench: clock, reset, stimulus and
// verdict; needs rsr_pkg, the block and rsr_run_checker
module replacement_selection_runs_tb;

  localparam int LIMIT           = 400000;
  localparam int SETTLE          = 4 * (rsr_pkg::SLOTS + 2);
  localparam int ITEMS_PER_PHASE = 140;
  localparam int LONG_STALL      = 400;

  typedef enum int {
    KEYS_WIDE,
    KEYS_NARROW,
    KEYS_RISING,
    KEYS_FALLING,
    KEYS_EXTREME
  } key_mix_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = rsr_pkg::OP_KEY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int errors;
  int pending;
  int keys_out;
  int runs_closed;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_asks  = 0;
  int stall_seen  = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int drains_sent = 0;
  int cfg_writes  = 0;

  logic [3:0] slot_settings [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd9, 4'd15};

  replacement_selection_runs u_top (.*);

  rsr_run_checker u_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d keys still due", cycle_count, pending);
    $display("[replacement_selection_runs] ERROR");
    $finish;
  end

  // receiver: random back-pressure, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (stall_asks != stall_seen) begin
        stall_seen++;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one item, after a random gap, and wait until it is taken
  task automatic send_item(input logic op, input logic [31:0] key);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (op == rsr_pkg::OP_DRAIN) drains_sent++;
  endtask

  // stop offering, wait for every key due, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slots(input logic [3:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_key(input key_mix_t mix, input logic [31:0] prev);
    case (mix)
      KEYS_NARROW:  return 32'(int'($urandom_range(16)) - 8);
      KEYS_RISING:  return prev + 32'($urandom_range(60)) - 32'd15;
      KEYS_FALLING: return prev - 32'($urandom_range(60)) + 32'd15;
      KEYS_EXTREME: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h8000_0001;
          default: return 32'h7FFF_FFFE;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  task automatic stream_keys(input int count, input key_mix_t mix);
    logic [31:0] k;
    k = $urandom;
    repeat (count) begin
      k = pick_key(mix, k);
      send_item(rsr_pkg::OP_KEY, k);
    end
  endtask

  // random sequences of keys and drains under one idling pattern
  task automatic random_phase(input int tx_pct, input int rx_pct, input bit with_stall);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    if (with_stall) begin
      // fill, then hold the receiver off while keys keep coming
      write_slots(4'd8);
      stream_keys(8, KEYS_WIDE);
      stall_asks++;
      stream_keys(30, KEYS_WIDE);
      send_item(rsr_pkg::OP_DRAIN, $urandom);
    end
    while (items_sent - start < ITEMS_PER_PHASE) begin
      if ($urandom_range(2) == 0) write_slots(slot_settings[$urandom_range(7)]);
      stream_keys($urandom_range(1, 24), key_mix_t'($urandom_range(4)));
      // slot count changed in the middle of a stream
      if ($urandom_range(3) == 0) begin
        write_slots(slot_settings[$urandom_range(7)]);
        stream_keys($urandom_range(1, 12), key_mix_t'($urandom_range(4)));
      end
      case ($urandom_range(9))
        0:       ;  // no drain: the stream runs on into the next sequence
        1: begin
          send_item(rsr_pkg::OP_DRAIN, $urandom);
          send_item(rsr_pkg::OP_DRAIN, $urandom);
        end
        default: send_item(rsr_pkg::OP_DRAIN, $urandom);
      endcase
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: drain with nothing held gives no result
    send_item(rsr_pkg::OP_DRAIN, 32'hDEAD_BEEF);
    write_slots(4'd3);
    send_item(rsr_pkg::OP_KEY, 32'd5);
    send_item(rsr_pkg::OP_KEY, 32'd5);
    send_item(rsr_pkg::OP_KEY, 32'h8000_0000);
    // smallest out, largest in; then the tie goes to the lower slot
    send_item(rsr_pkg::OP_KEY, 32'h7FFF_FFFF);
    send_item(rsr_pkg::OP_KEY, 32'd5);
    // smaller keys freeze until the run closes
    send_item(rsr_pkg::OP_KEY, 32'hFFFF_FFFF);
    send_item(rsr_pkg::OP_KEY, 32'd0);
    send_item(rsr_pkg::OP_KEY, 32'd0);
    send_item(rsr_pkg::OP_DRAIN, 32'h0000_0000);
    // short input: drain before the slots are full
    send_item(rsr_pkg::OP_KEY, 32'h0000_0042);
    send_item(rsr_pkg::OP_KEY, 32'hFFFF_FF00);
    send_item(rsr_pkg::OP_DRAIN, 32'hFFFF_FFFF);
    // zero acts as a single slot
    write_slots(4'd0);
    send_item(rsr_pkg::OP_KEY, 32'd7);
    send_item(rsr_pkg::OP_KEY, 32'd3);
    send_item(rsr_pkg::OP_KEY, 32'd9);
    send_item(rsr_pkg::OP_DRAIN, 32'h5555_5555);
    // above range acts as all slots, then lowered mid-stream
    write_slots(4'd15);
    stream_keys(10, KEYS_WIDE);
    write_slots(4'd2);
    send_item(rsr_pkg::OP_KEY, 32'h1234_5678);
    send_item(rsr_pkg::OP_DRAIN, 32'hAAAA_AAAA);

    random_phase(21, 56, 1'b0);
    random_phase(56, 21, 1'b0);
    random_phase(0, 0, 1'b1);

    $display("sent %0d items (%0d end-of-input) over %0d slot-count writes",
             items_sent, drains_sent, cfg_writes);
    $display("checked %0d run keys, %0d run ends, in %0d cycles",
             keys_out, runs_closed, cycle_count);
    if (errors == 0 && pending == 0) begin
      $display("[replacement_selection_runs] OK");
    end else begin
      if (pending != 0) $display("%0d expected keys never arrived", pending);
      $display("[replacement_selection_runs] ERROR");
    end
    $finish;
  end

endmodule

@@ replacement_selection_runs.f @@
rtl/rsr_pkg.sv
rtl/rsr_cell.sv
rtl/replacement_selection_runs.sv
tb/rsr_run_checker.sv
tb/replacement_selection_runs_tb.sv
